// ----- rtl/core/pidf_pkg.sv -----
// ----------------------------------------------------------------------------
// pidf_pkg
// Shared types and constants for the filtered-derivative PID unit.
// ----------------------------------------------------------------------------
package pidf_pkg;

  localparam int unsigned NumRegs = 7;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned DivSteps = 48;

  localparam logic [2:0] RegPropGain    = 3'd0;
  localparam logic [2:0] RegIntegGain   = 3'd1;
  localparam logic [2:0] RegDerivGain   = 3'd2;
  localparam logic [2:0] RegDriveFloor  = 3'd3;
  localparam logic [2:0] RegDriveCeil   = 3'd4;
  localparam logic [2:0] RegSamplePer   = 3'd5;
  localparam logic [2:0] RegSmoothWt    = 3'd6;

  localparam logic [30:0] DefaultPeriod = 31'd6554;
  localparam logic [16:0] WeightOne     = 17'd65536;
  localparam logic signed [31:0] CeilReset = 32'sd6553600;

  // Datapath operation codes issued by the controller
  typedef enum logic [3:0] {
    OpNone   = 4'd0,
    OpClear  = 4'd1,
    OpLoad   = 4'd2,
    OpProp   = 4'd3,
    OpDivSt  = 4'd4,
    OpDivIt  = 4'd5,
    OpSmA    = 4'd6,
    OpSmB    = 4'd7,
    OpDeriv  = 4'd8,
    OpIntT   = 4'd9,
    OpIntS   = 4'd10,
    OpSum    = 4'd11,
    OpClamp  = 4'd12
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

  // Saturate a signed 66-bit value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/pidf_datapath.sv -----
// ----------------------------------------------------------------------------
// pidf_datapath
// Registers, a shared combinational 33x34 multiplier and a
// one-bit-per-cycle restoring divider for the measurement rate.
// ----------------------------------------------------------------------------
module pidf_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  pidf_pkg::dp_cmd_t    cmd_i,
  input  logic signed [31:0]   target_i,
  input  logic signed [31:0]   measured_i,
  output pidf_pkg::dp_sts_t    sts_o,
  output logic signed [31:0]   drive_o
);
  import pidf_pkg::*;

  logic signed [31:0] kp_q, ki_q, kd_q, lo_q, hi_q;
  logic [30:0]        per_q;
  logic [16:0]        wt_q;
  logic signed [31:0] integ_q, last_q, srate_q;
  logic               fresh_q;
  logic signed [31:0] err_q, meas_q, p_q, d_q, t_q, ipro_q, rate_q, drive_q;
  logic signed [65:0] acc_q;
  logic signed [65:0] sum_q;
  // divider
  logic [47:0]        dquo_q;
  logic [31:0]        drem_q;
  logic               dneg_q;
  logic [5:0]         dcnt_q;

  logic [30:0]        per;
  logic [16:0]        wt;
  logic signed [32:0] ma;
  logic signed [33:0] mb;
  logic signed [66:0] prod;
  logic signed [65:0] flr;
  logic signed [32:0] diff;
  logic [32:0]        rem_sh;
  logic signed [49:0] qsgn;

  assign per = (per_q == '0) ? DefaultPeriod : per_q;
  assign wt  = (wt_q > WeightOne) ? WeightOne : wt_q;
  assign diff = 33'(meas_q) - 33'(last_q);

  // Select multiplier operands per operation
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OpProp:  begin ma = 33'(kp_q); mb = 34'(err_q); end
      OpSmA:   begin ma = 33'(srate_q); mb = 34'(signed'({17'd0, WeightOne - wt})); end
      OpSmB:   begin ma = 33'(rate_q);  mb = 34'(signed'({17'd0, wt})); end
      OpDeriv: begin ma = -33'(kd_q);   mb = 34'(srate_q); end
      OpIntT:  begin ma = 33'(ki_q);    mb = 34'(err_q); end
      OpIntS:  begin ma = 33'(t_q);     mb = 34'(signed'({3'd0, per})); end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = 67'(ma) * 67'(mb);
    flr  = 66'(prod >>> 16);
  end

  assign rem_sh = {drem_q, dquo_q[47]};
  assign qsgn   = dneg_q ? -50'(signed'({2'b0, dquo_q})) : 50'(signed'({2'b0, dquo_q}));

  // Sequence the datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0; ki_q <= '0; kd_q <= '0; lo_q <= '0; hi_q <= CeilReset;
      per_q <= DefaultPeriod; wt_q <= WeightOne;
      integ_q <= '0; last_q <= '0; srate_q <= '0; fresh_q <= 1'b1;
      dcnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPropGain:   kp_q  <= cfg_data_i;
          RegIntegGain:  ki_q  <= cfg_data_i;
          RegDerivGain:  kd_q  <= cfg_data_i;
          RegDriveFloor: lo_q  <= cfg_data_i;
          RegDriveCeil:  hi_q  <= cfg_data_i;
          RegSamplePer:  per_q <= cfg_data_i[30:0];
          RegSmoothWt:   wt_q  <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        OpClear: begin
          integ_q <= '0; last_q <= '0; srate_q <= '0; fresh_q <= 1'b1;
        end
        OpLoad: begin
          meas_q <= measured_i;
          err_q  <= sat32(66'(target_i) - 66'(measured_i));
        end
        OpProp: p_q <= sat32(flr);
        OpDivSt: begin
          // |diff| << 16 as dividend, shifted out one bit per cycle
          dquo_q <= {diff[32] ? 32'(-diff) : 32'(diff), 16'd0};
          drem_q <= '0;
          dneg_q <= diff[32];
          dcnt_q <= 6'(DivSteps);
        end
        OpDivIt: begin
          if (dcnt_q != '0) begin
            dcnt_q <= dcnt_q - 6'd1;
            if (rem_sh >= 33'(per)) begin
              drem_q <= 32'(rem_sh - 33'(per));
              dquo_q <= {dquo_q[46:0], 1'b1};
            end else begin
              drem_q <= rem_sh[31:0];
              dquo_q <= {dquo_q[46:0], 1'b0};
            end
          end else begin
            rate_q  <= fresh_q ? '0 : sat32(66'(qsgn));
            fresh_q <= 1'b0;
            last_q  <= meas_q;
          end
        end
        OpSmA:   acc_q <= 66'(prod);
        OpSmB:   srate_q <= sat32(66'((67'(acc_q) + prod) >>> 16));
        OpDeriv: d_q <= sat32(flr);
        OpIntT:  t_q <= sat32(flr);
        OpIntS:  ipro_q <= sat32(66'(integ_q) + 66'(sat32(flr)));
        OpSum:   sum_q <= 66'(p_q) + 66'(ipro_q) + 66'(d_q);
        OpClamp: begin
          logic signed [31:0] dv;
          dv = (sum_q < 66'(lo_q)) ? lo_q : (sum_q > 66'(hi_q)) ? hi_q : sum_q[31:0];
          drive_q <= dv;
          if (!(((dv >= hi_q) && (err_q > 0)) || ((dv <= lo_q) && (err_q < 0)))) begin
            integ_q <= ipro_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign sts_o.div_done = (cmd_i.op == OpDivIt) && (dcnt_q == '0);
  assign drive_o = drive_q;

  // Divider count never exceeds the step total
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) dcnt_q <= 6'(DivSteps))
    else $error("divider count out of range");
  // A clear leaves the start flag set
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OpClear |=> fresh_q) else $error("clear lost start flag");
  // Limits in order: drive stays within floor and ceiling when floor is not above it
  a_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OpClamp && lo_q <= hi_q) |=> (drive_q <= hi_q && drive_q >= lo_q))
    else $error("drive outside limits");

endmodule

// ----- rtl/core/pidf_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidf_ctrl
// One-hot controller: sequences one item through the datapath and holds the
// result until its transfer.
// ----------------------------------------------------------------------------
module pidf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  pidf_pkg::dp_sts_t  sts_i,
  output pidf_pkg::dp_cmd_t  cmd_o
);
  import pidf_pkg::*;

  typedef enum logic [10:0] {
    StIdle  = 11'b000_0000_0001,
    StProp  = 11'b000_0000_0010,
    StDivSt = 11'b000_0000_0100,
    StDivIt = 11'b000_0000_1000,
    StSmA   = 11'b000_0001_0000,
    StSmB   = 11'b000_0010_0000,
    StDeriv = 11'b000_0100_0000,
    StIntT  = 11'b000_1000_0000,
    StIntS  = 11'b001_0000_0000,
    StSum   = 11'b010_0000_0000,
    StClamp = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   take;

  // Accept a new item when idle and the output slot is free or draining
  assign in_ready_o = (state_q == StIdle) && (!ov_q || out_ready_i);
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o.op = OpNone;
    ov_d = ov_q && !out_ready_i;
    case (state_q)
      StIdle: if (take) begin
        cmd_o.op = kind_i ? OpClear : OpLoad;
        if (!kind_i) state_d = StProp;
      end
      StProp:  begin cmd_o.op = OpProp;  state_d = StDivSt; end
      StDivSt: begin cmd_o.op = OpDivSt; state_d = StDivIt; end
      StDivIt: begin
        cmd_o.op = OpDivIt;
        if (sts_i.div_done) state_d = StSmA;
      end
      StSmA:   begin cmd_o.op = OpSmA;   state_d = StSmB; end
      StSmB:   begin cmd_o.op = OpSmB;   state_d = StDeriv; end
      StDeriv: begin cmd_o.op = OpDeriv; state_d = StIntT; end
      StIntT:  begin cmd_o.op = OpIntT;  state_d = StIntS; end
      StIntS:  begin cmd_o.op = OpIntS;  state_d = StSum; end
      StSum:   begin cmd_o.op = OpSum;   state_d = StClamp; end
      StClamp: begin cmd_o.op = OpClamp; state_d = StIdle; ov_d = 1'b1; end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  a_oh: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_ready_o) else $error("ready while busy");
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClamp |=> out_valid_o) else $error("result not raised");

endmodule

// ----- rtl/core/pid_filtered_deriv_antiwindup_unit.sv -----
// ----------------------------------------------------------------------------
// pid_filtered_deriv_antiwindup_unit
// PID controller, derivative on measurement with one-pole smoother,
// saturating Q16.16 arithmetic and integrator hold at the drive limits.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | dir
//  in       | in_valid_i/in_ready_o, kind/target/meas   | in
//  out      | out_valid_o/out_ready_i, drive_o          | out
//  cfg      | cfg_we_i, cfg_idx_i, cfg_data_i           | in
//
// A compute item runs through the datapath steps one after another; the
// bit-serial rate divider among them takes 48 shift steps and a finish step,
// the rest one datapath step each.
// A clear item is applied at its transfer and gives no result.
// Reset restores the configuration, integrator, smoother and divider count
// registers and controller state at once. The result is held in an output
// register; a new item is taken when idle and the result is transferring or gone.
module pid_filtered_deriv_antiwindup_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic signed [31:0] target_i,
  input  logic signed [31:0] measured_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] drive_o
);
  import pidf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pidf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  pidf_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i(cmd), .target_i, .measured_i, .sts_o(sts), .drive_o
  );

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the filtered-derivative PID unit: items from a queue are driven with
// random gaps, drive values are predicted in Q16.16 and compared in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pidf_pkg::*;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] target;
    logic signed [31:0] measured;
  } pid_item_t;

  localparam int unsigned CycleLimit = 2_000_000;

  logic               clk, rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_idx;
  logic [31:0]        cfg_data;
  logic               in_valid, in_ready, out_valid, out_ready;
  logic               kind;
  logic signed [31:0] target, measured, drive;

  pid_item_t          pending_items[$];
  logic signed [31:0] expected_drives[$];
  int                 send_idle_pct, recv_stall_pct;
  int unsigned        cycle_cnt;
  bit                 failed;

  // Predictor registers and state
  logic signed [31:0] m_kp, m_ki, m_kd, m_floor, m_ceil;
  logic [30:0]        m_period;
  logic [16:0]        m_weight;
  logic signed [31:0] m_integ, m_last_meas, m_smooth;
  bit                 m_fresh;

  pid_filtered_deriv_antiwindup_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .target_i(target), .measured_i(measured),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .drive_o(drive)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic logic signed [31:0] clip32(input logic signed [95:0] v);
    if (v > 96'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -96'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Arithmetic shift right by 16 rounds toward minus infinity
  function automatic logic signed [95:0] floor16(input logic signed [95:0] v);
    return v >>> 16;
  endfunction

  function automatic void reset_model();
    m_kp = 0; m_ki = 0; m_kd = 0; m_floor = 0; m_ceil = CeilReset;
    m_period = DefaultPeriod; m_weight = WeightOne;
    m_integ = 0; m_last_meas = 0; m_smooth = 0; m_fresh = 1;
  endfunction

  function automatic void write_model_reg(input logic [2:0] idx,
                                          input logic [31:0] val);
    case (idx)
      RegPropGain:   m_kp = val;
      RegIntegGain:  m_ki = val;
      RegDerivGain:  m_kd = val;
      RegDriveFloor: m_floor = val;
      RegDriveCeil:  m_ceil = val;
      RegSamplePer:  m_period = val[30:0];
      RegSmoothWt:   m_weight = val[16:0];
      default: ;
    endcase
  endfunction

  // Advance the controller state for one item and queue its drive value, if any
  function automatic void predict_drive(input pid_item_t it);
    logic signed [95:0] per, w, rate, sum, t, stp, ipro, diff;
    logic signed [31:0] err, p, d, drv;
    if (it.kind) begin
      m_integ = 0; m_last_meas = 0; m_smooth = 0; m_fresh = 1;
      return;
    end
    err = clip32(96'(it.target) - 96'(it.measured));
    per = (m_period != 0) ? 96'(m_period) : 96'(DefaultPeriod);
    w = (m_weight > WeightOne) ? 96'(WeightOne) : 96'(m_weight);
    p = clip32(floor16(96'(m_kp) * 96'(err)));
    if (m_fresh) begin
      rate = 0;
      m_fresh = 0;
    end else begin
      diff = (96'(it.measured) - 96'(m_last_meas)) * 96'sd65536;
      rate = clip32(diff / per);
    end
    m_last_meas = it.measured;
    m_smooth = clip32(floor16((96'sd65536 - w) * 96'(m_smooth) + w * rate));
    d = clip32(floor16(-(96'(m_kd) * 96'(m_smooth))));
    t = clip32(floor16(96'(m_ki) * 96'(err)));
    stp = clip32(floor16(t * per));
    ipro = clip32(96'(m_integ) + stp);
    sum = 96'(p) + ipro + 96'(d);
    if (sum < 96'(m_floor)) drv = m_floor;
    else if (sum > 96'(m_ceil)) drv = m_ceil;
    else drv = sum[31:0];
    if (!((drv >= m_ceil && err > 0) || (drv <= m_floor && err < 0))) begin
      m_integ = ipro[31:0];
    end
    expected_drives.push_back(drv);
  endfunction

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endcase
  endfunction

  // Driver: present the head of the queue, hold until transfer
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      kind <= 1'b0; target <= '0; measured <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_drive({kind, target, measured});
      if (pending_items.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
        in_valid <= 1'b1;
        {kind, target, measured} <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each transfer with the oldest expectation
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          $display("%t unexpected drive: expected none, actual %0d", $realtime, drive);
          failed = 1;
        end else begin
          if (drive !== expected_drives[0]) begin
            $display("%t drive mismatch: expected %0d, actual %0d",
                     $realtime, expected_drives[0], drive);
            failed = 1;
          end
          void'(expected_drives.pop_front());
        end
      end
      out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_drives.size() != 0)
      @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // Drive the write enable with index and data, then drop the enable and leave an idle gap before returning
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    write_model_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_phase(input int n);
    pid_item_t it;
    repeat (n) begin
      it.kind = ($urandom_range(0, 19) == 0);
      it.target = rand_q16();
      it.measured = rand_q16();
      pending_items.push_back(it);
    end
  endtask

  initial begin
    failed = 0; cycle_cnt = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    cfg_we = 0; cfg_idx = RegPropGain; cfg_data = '0;
    reset_model();
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults, extremes of fields, clear items
    pending_items.push_back({1'b0, 32'sh0001_0000, 32'sh0000_0000});
    pending_items.push_back({1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000});
    pending_items.push_back({1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF});
    pending_items.push_back({1'b1, 32'shFFFF_FFFF, 32'shFFFF_FFFF});
    pending_items.push_back({1'b0, 32'sh0000_0000, 32'sh0000_0000});
    wait_drained();

    write_reg(RegPropGain, 32'sh0002_0000);
    write_reg(RegIntegGain, 32'sh0001_8000);
    write_reg(RegDerivGain, 32'sh0000_4000);
    write_reg(RegDriveFloor, -32'sh0064_0000);
    write_reg(RegSamplePer, 32'd0);
    write_reg(RegSmoothWt, 32'h1FFFF);
    pending_items.push_back({1'b0, 32'sh0010_0000, 32'sh0000_0000});
    pending_items.push_back({1'b0, 32'sh0010_0000, 32'sh0008_0000});
    pending_items.push_back({1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000});
    pending_items.push_back({1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF});
    pending_items.push_back({1'b0, 32'sh8000_0000, 32'sh8000_0000});
    pending_items.push_back({1'b1, 32'sh0, 32'sh0});
    pending_items.push_back({1'b0, 32'sh0000_1000, 32'shFFFF_0000});
    wait_drained();

    // Crossed limits, longest sample period and zero smoothing weight
    write_reg(RegDriveFloor, 32'sh0010_0000);
    write_reg(RegDriveCeil, -32'sh0010_0000);
    write_reg(RegSamplePer, 32'h7FFF_FFFF);
    write_reg(RegSmoothWt, 32'd0);
    pending_items.push_back({1'b0, 32'sh0000_0000, 32'sh0040_0000});
    pending_items.push_back({1'b0, 32'sh0040_0000, 32'sh0000_0000});
    pending_items.push_back({1'b0, 32'sh0000_0000, 32'sh0000_0000});
    wait_drained();

    // Random phases over several settings and idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      write_reg(RegPropGain, (ph == 4) ? 32'h8000_0000 : $urandom_range(0, 32'h0004_0000));
      write_reg(RegIntegGain, (ph == 5) ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0004_0000));
      write_reg(RegDerivGain, (ph == 6) ? 32'h8000_0000 : $urandom);
      write_reg(RegDriveFloor, (ph == 7) ? 32'h8000_0000 : -$urandom_range(0, 32'h0100_0000));
      write_reg(RegDriveCeil, (ph == 7) ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0100_0000));
      write_reg(RegSamplePer, (ph == 2) ? 32'd1 : $urandom);
      write_reg(RegSmoothWt, $urandom_range(0, 17'h1FFFF));
      load_phase(125);
      wait_drained();
    end

    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
